>>> hdl/kcs_pkg.sv
// Shared constants and types for the Kraus superoperator engine.
`default_nettype none

package kcs_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    // Sign bit plus four integer bits; the rest are fraction bits.
    localparam int INT_BITS        = 5;
    localparam int IO_W            = 32;
    localparam int N_ELEM          = 4;
    localparam int N_ENT           = N_ELEM * N_ELEM;
    localparam int FUNC_W          = 2;
    localparam int IN_DATA_W       = 2 * N_ELEM * IO_W;
    localparam int OUT_DATA_W      = 2 * N_ELEM * IO_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_APPLY = 2'd2
    } t_func;

    typedef struct packed {
        logic clear;
        logic add;
    } t_store_ctl;

endpackage

`default_nettype wire

>>> hdl/kcs_cmul.sv
// One complex product lane: four real products, each rounded to the fraction width.
`default_nettype none

module kcs_cmul #(
    parameter int VALUE_WIDTH = kcs_pkg::VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0]                              i_a_re,
    input  logic signed [VALUE_WIDTH-1:0]                              i_a_im,
    input  logic signed [VALUE_WIDTH-1:0]                              i_b_re,
    input  logic signed [VALUE_WIDTH-1:0]                              i_b_im,
    output logic signed [2*VALUE_WIDTH-(VALUE_WIDTH-kcs_pkg::INT_BITS)-1:0] o_p_rr,
    output logic signed [2*VALUE_WIDTH-(VALUE_WIDTH-kcs_pkg::INT_BITS)-1:0] o_p_ii,
    output logic signed [2*VALUE_WIDTH-(VALUE_WIDTH-kcs_pkg::INT_BITS)-1:0] o_p_ir,
    output logic signed [2*VALUE_WIDTH-(VALUE_WIDTH-kcs_pkg::INT_BITS)-1:0] o_p_ri
);
    import kcs_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int F  = W - INT_BITS;
    localparam int PW = 2 * W;

    localparam logic signed [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [PW-1:0] full_rr, full_ii, full_ir, full_ri;
    logic signed [PW-1:0] rnd_rr, rnd_ii, rnd_ir, rnd_ri;

    assign full_rr = i_a_re * i_b_re;
    assign full_ii = i_a_im * i_b_im;
    assign full_ir = i_a_im * i_b_re;
    assign full_ri = i_a_re * i_b_im;

    // Round half up, then floor by dropping the fraction bits.
    assign rnd_rr = full_rr + HALF;
    assign rnd_ii = full_ii + HALF;
    assign rnd_ir = full_ir + HALF;
    assign rnd_ri = full_ri + HALF;

    assign o_p_rr = rnd_rr[PW-1:F];
    assign o_p_ii = rnd_ii[PW-1:F];
    assign o_p_ir = rnd_ir[PW-1:F];
    assign o_p_ri = rnd_ri[PW-1:F];

endmodule

`default_nettype wire

>>> hdl/kcs_superop.sv
// Superoperator store: sixteen complex entries with clear and saturating accumulate.
`default_nettype none

module kcs_superop #(
    parameter int VALUE_WIDTH = kcs_pkg::VALUE_WIDTH_DEF,
    parameter int DELTA_WIDTH = kcs_pkg::VALUE_WIDTH_DEF + 6
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  kcs_pkg::t_store_ctl                             i_ctl,
    input  logic [kcs_pkg::N_ENT-1:0][DELTA_WIDTH-1:0]      i_d_re,
    input  logic [kcs_pkg::N_ENT-1:0][DELTA_WIDTH-1:0]      i_d_im,
    output logic [kcs_pkg::N_ENT-1:0][VALUE_WIDTH-1:0]      o_s_re,
    output logic [kcs_pkg::N_ENT-1:0][VALUE_WIDTH-1:0]      o_s_im
);
    import kcs_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int AW = DELTA_WIDTH + 1;

    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    logic [N_ENT-1:0][W-1:0] r_re, r_im;
    logic [N_ENT-1:0][W-1:0] n_re, n_im;

    for (genvar k = 0; k < N_ENT; k++) begin : g_ent
        logic signed [AW-1:0] sum_re, sum_im;
        logic [W-1:0]         sat_re, sat_im;

        assign sum_re = AW'(signed'(r_re[k])) + AW'(signed'(i_d_re[k]));
        assign sum_im = AW'(signed'(r_im[k])) + AW'(signed'(i_d_im[k]));

        // Clamp when the bits above the sign disagree.
        always_comb begin
            if (sum_re[AW-1:W-1] != '0 && sum_re[AW-1:W-1] != '1) begin
                sat_re = sum_re[AW-1] ? MIN_V : MAX_V;
            end else begin
                sat_re = sum_re[W-1:0];
            end
            if (sum_im[AW-1:W-1] != '0 && sum_im[AW-1:W-1] != '1) begin
                sat_im = sum_im[AW-1] ? MIN_V : MAX_V;
            end else begin
                sat_im = sum_im[W-1:0];
            end
        end

        always_comb begin
            priority if (i_ctl.clear) begin
                n_re[k] = '0;
                n_im[k] = '0;
            end else if (i_ctl.add) begin
                n_re[k] = sat_re;
                n_im[k] = sat_im;
            end else begin
                n_re[k] = r_re[k];
                n_im[k] = r_im[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re <= '0;
            r_im <= '0;
        end else begin
            r_re <= n_re;
            r_im <= n_im;
        end
    end

    assign o_s_re = r_re;
    assign o_s_im = r_im;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_re == '0 && r_im == '0))
        else $error("superoperator not zero after clear");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.clear || i_ctl.add) |=> ($stable(r_re) && $stable(r_im)))
        else $error("superoperator changed without a write");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctl.clear, i_ctl.add}))
        else $error("clear and add requested together");

endmodule

`default_nettype wire

>>> hdl/kraus_channel_superop_apply.sv
// Top level of the single-qubit Kraus superoperator engine.
//
// Requests enter on the s_axis channel: tuser carries the function code,
// tdata four complex values. Clear (code 0) zeroes the 4x4 superoperator,
// add (code 1) folds one Kraus operator K into it as K x conj(K), apply
// (code 2) multiplies the superoperator by one density-matrix fiber and
// sends the four complex components out on m_axis. Code 3 is taken and
// dropped. Only apply produces an output request.
// Pipeline: input register, rounded-product register (sixteen complex
// multiplier lanes shared by add and apply), output register. An apply
// result goes from the product stage to the output register; a clear or
// add lands in the superoperator as it leaves the product stage. Throughput
// is one request per cycle unless the receiver stalls or an apply directly
// follows a clear or add; that apply holds in the input register while
// the write in the product stage updates the superoperator it would read.
// Reset clears the superoperator to zero and empties all stages. When the
// receiver stalls, the output register holds its result and the product and
// input stages keep filling; writes always drain from the product stage.
`default_nettype none

module kraus_channel_superop_apply #(
    parameter int VALUE_WIDTH = kcs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // a0_re, a0_im, a1_re, a1_im, a2_re, a2_im, a3_re, a3_im (32 bits each)
    input  logic [kcs_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func
    input  logic [kcs_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // q0_re, q0_im, q1_re, q1_im, q2_re, q2_im, q3_re, q3_im (32 bits each)
    output logic [kcs_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import kcs_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int F  = W - INT_BITS;
    localparam int RW = 2 * W - F;      // rounded product width
    localparam int DW = RW + 1;         // add delta: two products
    localparam int SW = RW + 3;         // apply sum: eight products
    localparam int NC = 2 * N_ELEM;     // real/imag components

    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    // ---------------------------------------------------------------
    // Handshake and stage control
    // ---------------------------------------------------------------
    logic  r_s0_vld, r_s1_vld, r_s2_vld;
    t_func r_s0_func, r_s1_func;
    logic  func_ok, s_acc;
    logic  s2_free, adv1, s1_free, hazard, adv0;

    assign func_ok = (i_s_axis_tuser == FUNC_CLEAR) || (i_s_axis_tuser == FUNC_ADD)
                     || (i_s_axis_tuser == FUNC_APPLY);

    assign s2_free = !r_s2_vld || i_m_axis_tready;
    // Writes leave the product stage at once; apply waits for the output register.
    assign adv1    = r_s1_vld && (r_s1_func != FUNC_APPLY || s2_free);
    assign s1_free = !r_s1_vld || adv1;
    // Hold an apply while a superoperator write is still in flight.
    assign hazard  = r_s0_vld && r_s0_func == FUNC_APPLY
                     && r_s1_vld && r_s1_func != FUNC_APPLY;
    assign adv0    = r_s0_vld && s1_free && !hazard;

    assign o_s_axis_tready = !r_s0_vld || adv0;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    logic [NC-1:0][W-1:0] r_s0_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            // Drop the unused code here.
            r_s0_vld <= i_s_axis_tvalid && func_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s0_func <= t_func'(i_s_axis_tuser);
            for (int c = 0; c < NC; c++) begin
                r_s0_x[c] <= i_s_axis_tdata[c*IO_W +: W];
            end
        end
    end

    // ---------------------------------------------------------------
    // Multiplier lanes
    // ---------------------------------------------------------------
    logic [N_ENT-1:0][W-1:0] s_re, s_im;
    logic signed [RW-1:0]    p_rr [N_ENT];
    logic signed [RW-1:0]    p_ii [N_ENT];
    logic signed [RW-1:0]    p_ir [N_ENT];
    logic signed [RW-1:0]    p_ri [N_ENT];
    logic                    sel_apply;

    assign sel_apply = (r_s0_func == FUNC_APPLY);

    for (genvar k = 0; k < N_ENT; k++) begin : g_lane
        // Add: entry (2ro+co, 2ri+ci) pairs K[ro][ri] with conj K[co][ci].
        localparam int AI = 2 * (k / 8) + (k / 2) % 2;
        localparam int BI = 2 * ((k / 4) % 2) + k % 2;
        // Apply: entry (po, pi) meets fiber element pi.
        localparam int PI = k % 4;

        logic signed [W-1:0] a_re, a_im, b_re, b_im;

        assign a_re = sel_apply ? s_re[k] : r_s0_x[2*AI];
        assign a_im = sel_apply ? s_im[k] : r_s0_x[2*AI+1];
        assign b_re = sel_apply ? r_s0_x[2*PI]   : r_s0_x[2*BI];
        assign b_im = sel_apply ? r_s0_x[2*PI+1] : r_s0_x[2*BI+1];

        kcs_cmul #(
            .VALUE_WIDTH(W)
        ) u_cmul (
            .i_a_re(a_re),
            .i_a_im(a_im),
            .i_b_re(b_re),
            .i_b_im(b_im),
            .o_p_rr(p_rr[k]),
            .o_p_ii(p_ii[k]),
            .o_p_ir(p_ir[k]),
            .o_p_ri(p_ri[k])
        );
    end

    // ---------------------------------------------------------------
    // Stage 1: rounded-product register
    // ---------------------------------------------------------------
    logic signed [RW-1:0] r_s1_rr [N_ENT];
    logic signed [RW-1:0] r_s1_ii [N_ENT];
    logic signed [RW-1:0] r_s1_ir [N_ENT];
    logic signed [RW-1:0] r_s1_ri [N_ENT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= adv0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s1_func <= r_s0_func;
            r_s1_rr   <= p_rr;
            r_s1_ii   <= p_ii;
            r_s1_ir   <= p_ir;
            r_s1_ri   <= p_ri;
        end
    end

    // ---------------------------------------------------------------
    // Superoperator update from the product stage
    // ---------------------------------------------------------------
    t_store_ctl               st_ctl;
    logic [N_ENT-1:0][DW-1:0] d_re, d_im;

    assign st_ctl.clear = adv1 && r_s1_func == FUNC_CLEAR;
    assign st_ctl.add   = adv1 && r_s1_func == FUNC_ADD;

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            d_re[k] = DW'(r_s1_rr[k]) + DW'(r_s1_ii[k]);
            d_im[k] = DW'(r_s1_ir[k]) - DW'(r_s1_ri[k]);
        end
    end

    kcs_superop #(
        .VALUE_WIDTH(W),
        .DELTA_WIDTH(DW)
    ) u_superop (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (st_ctl),
        .i_d_re (d_re),
        .i_d_im (d_im),
        .o_s_re (s_re),
        .o_s_im (s_im)
    );

    // ---------------------------------------------------------------
    // Apply sums, saturation and stage 2 output register
    // ---------------------------------------------------------------
    logic signed [SW-1:0] sum_c [NC];
    logic [NC-1:0][W-1:0] n_s2_q, r_s2_q;

    always_comb begin
        for (int po = 0; po < N_ELEM; po++) begin
            sum_c[2*po]   = '0;
            sum_c[2*po+1] = '0;
            for (int pi = 0; pi < N_ELEM; pi++) begin
                sum_c[2*po]   = sum_c[2*po] + SW'(r_s1_rr[po*N_ELEM+pi])
                                - SW'(r_s1_ii[po*N_ELEM+pi]);
                sum_c[2*po+1] = sum_c[2*po+1] + SW'(r_s1_ri[po*N_ELEM+pi])
                                + SW'(r_s1_ir[po*N_ELEM+pi]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (sum_c[c][SW-1:W-1] != '0 && sum_c[c][SW-1:W-1] != '1) begin
                n_s2_q[c] = sum_c[c][SW-1] ? MIN_V : MAX_V;
            end else begin
                n_s2_q[c] = sum_c[c][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_free) begin
            r_s2_vld <= adv1 && r_s1_func == FUNC_APPLY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && adv1 && r_s1_func == FUNC_APPLY) begin
            r_s2_q <= n_s2_q;
        end
    end

    assign o_m_axis_tvalid = r_s2_vld;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            o_m_axis_tdata[c*IO_W +: IO_W] = IO_W'(signed'(r_s2_q[c]));
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_func == FUNC_APPLY && $past(adv0))
        |-> !$past(r_s1_vld && r_s1_func != FUNC_APPLY))
        else $error("apply read superoperator behind a pending write");

    a_result_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_s1_vld && r_s1_func == FUNC_APPLY))
        else $error("output request without an apply in the product stage");

    a_write_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_func != FUNC_APPLY) |=> (!r_s1_vld || $past(adv0)))
        else $error("superoperator write stalled in the product stage");

endmodule

`default_nettype wire

>>> test/kraus_channel_superop_apply_chk.sv
// Checker for the Kraus superoperator engine: channel monitor, predictor and comparison.
module kraus_channel_superop_apply_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // a0_re, a0_im, a1_re, a1_im, a2_re, a2_im, a3_re, a3_im (32 bits each)
    input  logic [kcs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // func
    input  logic [kcs_pkg::FUNC_W-1:0]     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // q0_re, q0_im, q1_re, q1_im, q2_re, q2_im, q3_re, q3_im (32 bits each)
    input  logic [kcs_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_pending,
    output int                             o_fail_count,
    output int                             o_checked
);
    import kcs_pkg::*;

    localparam int     FRAC     = VALUE_WIDTH_DEF - INT_BITS;
    localparam longint WIDE_MAX = (64'sd1 <<< (VALUE_WIDTH_DEF - 1)) - 1;
    localparam longint WIDE_MIN = -(64'sd1 <<< (VALUE_WIDTH_DEF - 1));

    // One output request: components in tdata order, re then im per element.
    typedef struct packed {
        logic [N_ELEM-1:0][1:0][IO_W-1:0] comp;
    } t_fiber;

    longint sop_re [N_ENT];
    longint sop_im [N_ENT];
    longint in_re  [N_ELEM];
    longint in_im  [N_ELEM];
    t_fiber fiber_q[$];

    // Each real product rounds on its own: add half an LSB, floor-shift.
    function automatic longint round_mul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic longint saturate(input longint v);
        if (v > WIDE_MAX) return WIDE_MAX;
        if (v < WIDE_MIN) return WIDE_MIN;
        return v;
    endfunction

    task automatic report_fail(input string msg);
        $display("[%0t] kcs check: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_fiber got;
        t_fiber want;
        longint acc_re;
        longint acc_im;
        longint tr;
        longint ti;
        int     a;
        int     b;
        int     idx;
        if (!i_rst_n) begin
            foreach (sop_re[e]) begin
                sop_re[e] = 0;
                sop_im[e] = 0;
            end
            fiber_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                for (int k = 0; k < N_ELEM; k++) begin
                    in_re[k] = longint'($signed(i_s_tdata[(2*k)*IO_W +: IO_W]));
                    in_im[k] = longint'($signed(i_s_tdata[(2*k+1)*IO_W +: IO_W]));
                end
                case (i_s_tuser)
                    FUNC_CLEAR: begin
                        foreach (sop_re[e]) begin
                            sop_re[e] = 0;
                            sop_im[e] = 0;
                        end
                    end
                    FUNC_ADD: begin
                        // Fold K[ro][ri] * conj(K[co][ci]) into row 2ro+co, column 2ri+ci.
                        for (int ro = 0; ro < 2; ro++)
                        for (int co = 0; co < 2; co++)
                        for (int ri = 0; ri < 2; ri++)
                        for (int ci = 0; ci < 2; ci++) begin
                            a   = 2 * ro + ri;
                            b   = 2 * co + ci;
                            idx = (2 * ro + co) * N_ELEM + 2 * ri + ci;
                            tr  = round_mul(in_re[a], in_re[b]) + round_mul(in_im[a], in_im[b]);
                            ti  = round_mul(in_im[a], in_re[b]) - round_mul(in_re[a], in_im[b]);
                            sop_re[idx] = saturate(sop_re[idx] + tr);
                            sop_im[idx] = saturate(sop_im[idx] + ti);
                        end
                    end
                    FUNC_APPLY: begin
                        for (int po = 0; po < N_ELEM; po++) begin
                            acc_re = 0;
                            acc_im = 0;
                            for (int pi = 0; pi < N_ELEM; pi++) begin
                                idx = po * N_ELEM + pi;
                                acc_re += round_mul(sop_re[idx], in_re[pi])
                                        - round_mul(sop_im[idx], in_im[pi]);
                                acc_im += round_mul(sop_re[idx], in_im[pi])
                                        + round_mul(sop_im[idx], in_re[pi]);
                            end
                            want.comp[po][0] = IO_W'(saturate(acc_re));
                            want.comp[po][1] = IO_W'(saturate(acc_im));
                        end
                        fiber_q.push_back(want);
                    end
                    default: ;  // unused code: dropped without effect
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (fiber_q.size() == 0) begin
                    report_fail("output request with no apply pending");
                end else begin
                    want = fiber_q.pop_front();
                    o_checked++;
                    for (int k = 0; k < N_ELEM; k++) begin
                        if (got.comp[k][0] !== want.comp[k][0])
                            report_fail($sformatf("result %0d q%0d_re: got %h, expected %h",
                                o_checked, k, got.comp[k][0], want.comp[k][0]));
                        if (got.comp[k][1] !== want.comp[k][1])
                            report_fail($sformatf("result %0d q%0d_im: got %h, expected %h",
                                o_checked, k, got.comp[k][1], want.comp[k][1]));
                    end
                end
            end
        end
        o_pending <= fiber_q.size();
    end

endmodule

>>> test/kraus_channel_superop_apply_tb.sv
// Testbench top for the Kraus superoperator engine: stimulus, flow control and verdict.
module kraus_channel_superop_apply_tb;
    import kcs_pkg::*;

    localparam int          ITEM_TARGET    = 1550;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 8;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
    // Q4.27 landmarks
    localparam logic [31:0] V_ONE  = 32'h0800_0000;
    localparam logic [31:0] V_HALF = 32'h0400_0000;
    localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] V_MIN  = 32'h8000_0000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATTERN,
        RX_RANDOM,
        RX_HOLD
    } t_rx_mode;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int pending;
    int fail_count;
    int checked;
    int burst_left = 0;
    int n_clear    = 0;
    int n_add      = 0;
    int n_apply    = 0;
    int n_ignored  = 0;

    always #5 i_clk = ~i_clk;

    kraus_channel_superop_apply uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    kraus_channel_superop_apply_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    // Pack four complex elements, element 0 real part in the lowest bits.
    function automatic logic [IN_DATA_W-1:0] pack_elems(
        input logic [31:0] r0, input logic [31:0] i0, input logic [31:0] r1, input logic [31:0] i1,
        input logic [31:0] r2, input logic [31:0] i2, input logic [31:0] r3, input logic [31:0] i3
    );
        return {i3, r3, i2, r2, i1, r1, i0, r0};
    endfunction

    // Operator-sized values for the largest share, with full-range words and landmarks mixed in.
    function automatic logic [31:0] random_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            case (pick)
                0:       return V_MAX;
                1:       return V_MIN;
                2:       return '0;
                3:       return V_ONE;
                4:       return -V_ONE;
                5:       return 32'd1;
                default: return '1;
            endcase
        end
        if (pick < 12) return $urandom;
        return $urandom_range(0, 2 * V_ONE) - V_ONE;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_data();
        return pack_elems(random_value(), random_value(), random_value(), random_value(),
                          random_value(), random_value(), random_value(), random_value());
    endfunction

    // Present one request and hold it until taken. Bursts of back-to-back
    // requests alternate with idle gaps; a zero gap merges two bursts.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= func;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        case (func)
            FUNC_CLEAR: n_clear++;
            FUNC_ADD:   n_add++;
            FUNC_APPLY: n_apply++;
            default:    n_ignored++;
        endcase
    endtask

    // Stop sending and wait until every apply request has been answered.
    task automatic drain_requests();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: pick a new stall style whenever the phase counter runs out.
    t_rx_mode   rx_mode  = RX_OPEN;
    int         rx_phase = 0;
    logic [15:0] rx_mask = '1;

    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            rx_mask  = 16'($urandom) | 16'h0001;
            rx_phase = 48;
        end
        rx_phase--;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_PATTERN: m_tready <= rx_mask[rx_phase % 16];
            RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
            default:    m_tready <= (rx_phase % 16) >= 12;  // long holds, short release
        endcase
    end

    // Watchdog: end the run if neither channel moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** kraus_channel_superop_apply: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int n_kraus;
        int n_fiber;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Apply on the reset superoperator gives zeros.
        send_request(FUNC_APPLY, pack_elems(V_MAX, V_MAX, V_MAX, V_MAX,
                                            V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(FUNC_UNUSED, pack_elems(V_MIN, V_MIN, V_MIN, V_MIN,
                                             V_MIN, V_MIN, V_MIN, V_MIN));
        send_request(FUNC_APPLY, random_data());
        // Identity Kraus operator, then extreme fibers through it.
        send_request(FUNC_ADD, pack_elems(V_ONE, 0, 0, 0, 0, 0, V_ONE, 0));
        send_request(FUNC_APPLY, pack_elems(V_MAX, V_MAX, V_MAX, V_MAX,
                                            V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(FUNC_APPLY, pack_elems(V_MIN, V_MIN, V_MIN, V_MIN,
                                            V_MIN, V_MIN, V_MIN, V_MIN));
        send_request(FUNC_APPLY, pack_elems(1, '1, 1, '1, '1, 1, '1, 1));
        // Full-scale operators drive the accumulators into saturation.
        send_request(FUNC_ADD, pack_elems(V_MAX, V_MAX, V_MAX, V_MAX,
                                          V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(FUNC_ADD, pack_elems(V_MIN, V_MIN, V_MIN, V_MIN,
                                          V_MIN, V_MIN, V_MIN, V_MIN));
        // Saturated superoperator against extreme fibers overflows the outputs.
        send_request(FUNC_APPLY, pack_elems(V_MAX, V_MAX, V_MAX, V_MAX,
                                            V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(FUNC_APPLY, pack_elems(V_MIN, V_MIN, V_MIN, V_MIN,
                                            V_MIN, V_MIN, V_MIN, V_MIN));
        // Unused code must leave the loaded superoperator alone.
        send_request(FUNC_UNUSED, random_data());
        send_request(FUNC_APPLY, pack_elems(V_ONE, -V_ONE, V_ONE, -V_ONE,
                                            -V_ONE, V_ONE, -V_ONE, V_ONE));
        send_request(FUNC_CLEAR, random_data());
        send_request(FUNC_APPLY, pack_elems(V_MAX, V_MAX, V_MAX, V_MAX,
                                            V_MAX, V_MAX, V_MAX, V_MAX));
        // Half-strength Pauli-Y plus a most-negative operator.
        send_request(FUNC_ADD, pack_elems(0, 0, 0, -V_HALF, 0, V_HALF, 0, 0));
        send_request(FUNC_ADD, pack_elems(V_MIN, V_MIN, V_MIN, V_MIN,
                                          V_MIN, V_MIN, V_MIN, V_MIN));
        send_request(FUNC_APPLY, pack_elems(V_ONE, 0, V_HALF, V_HALF, V_HALF, -V_HALF, 0, 0));
        send_request(FUNC_CLEAR, '0);
        send_request(FUNC_ADD, pack_elems(V_HALF, -V_HALF, V_MAX, 0, 0, V_MIN, -V_ONE, V_ONE));
        send_request(FUNC_APPLY, random_data());
        send_request(FUNC_APPLY, '0);
        // Clear, load and apply back to back to hit the read-after-write hold.
        send_request(FUNC_CLEAR, '0);
        send_request(FUNC_ADD, pack_elems(V_ONE, 0, 0, 0, 0, 0, V_ONE, 0));
        send_request(FUNC_APPLY, random_data());
        drain_requests();

        // Random part: mostly channel loads followed by fiber streams, with
        // some noise sequences of arbitrary codes in between.
        while (n_clear + n_add + n_apply < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_request(FUNC_W'($urandom_range(0, 3)), random_data());
            end else begin
                if ($urandom_range(0, 6) != 0)
                    send_request(FUNC_CLEAR, random_data());
                n_kraus = $urandom_range(1, 4);
                repeat (n_kraus) begin
                    send_request(FUNC_ADD, random_data());
                    if ($urandom_range(0, 15) == 0)
                        send_request(FUNC_UNUSED, random_data());
                end
                n_fiber = $urandom_range(1, 12);
                repeat (n_fiber) begin
                    send_request(FUNC_APPLY, random_data());
                    if ($urandom_range(0, 15) == 0)
                        send_request(FUNC_UNUSED, random_data());
                end
            end
            if ($urandom_range(0, 7) == 0)
                drain_requests();
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d clears, %0d Kraus loads, %0d fiber applies, %0d unused codes",
                 n_clear, n_add, n_apply, n_ignored);
        $display("compared %0d output fibers against the predicted superoperator", checked);
        if (fail_count == 0) begin
            $display("** kraus_channel_superop_apply: PASSED **");
        end else begin
            $display("** kraus_channel_superop_apply: FAILED **");
        end
        $finish;
    end

endmodule
